>>> hw/rtl/yay0_pkg.sv
// ----------------------------------------------------------------------------
// yay0_pkg
// Shared types and constants of the Yay0 decompressor.
// ----------------------------------------------------------------------------
package yay0_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int LANES_DEF        = 8;
  localparam int DIST_W           = 12;
  localparam int CNT_W            = 9;
  localparam logic [7:0] LONG_CNT_BIAS = 8'h12;

  typedef enum logic [1:0] {
    ACT_CMD   = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_LINK  = 2'd2,
    ACT_START = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_LIT  = 2'd1,
    KIND_LINK = 2'd2,
    KIND_CNT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

  typedef struct packed {
    logic load_in;
    logic apply_single;
    logic copy_start;
    logic rd;
    logic wr;
    logic emit_copy;
  } cmd_t;

  typedef struct packed {
    logic is_copy;
    logic flush;
    logic copy_end;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/yay0_ctrl.sv
// ----------------------------------------------------------------------------
// yay0_ctrl
// Sequencer: takes an item, then issues one result or a copy loop.
// ----------------------------------------------------------------------------
module yay0_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  yay0_pkg::stat_t st,
  output yay0_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_RD, S_WR, S_CHK} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.is_copy) begin
          cmd.copy_start = 1'b1;
          state_nxt      = S_RD;
        end else if (st.out_free) begin
          cmd.apply_single = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!st.flush) begin
          state_nxt = S_RD;
        end else if (st.out_free) begin
          cmd.emit_copy = 1'b1;
          state_nxt     = st.copy_end ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/yay0_dp.sv
// ----------------------------------------------------------------------------
// yay0_dp
// Datapath: stream state, history memory, copy engine and result register.
// ----------------------------------------------------------------------------
module yay0_dp #(
  parameter int WINDOW_DEPTH = yay0_pkg::WINDOW_DEPTH_DEF,
  parameter int LANES        = yay0_pkg::LANES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  yay0_pkg::cmd_t  cmd,
  output yay0_pkg::stat_t st,
  input  logic [1:0]      in_action,
  input  logic [31:0]     in_word,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [31:0]     cfg_total_size,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_bytes [8],
  output logic [3:0]      out_byte_count,
  output logic            out_last,
  output logic [1:0]      out_status
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int LANE_W = (LANES > 8) ? 8 : LANES;
  localparam logic [3:0] LANE_W4 = 4'(LANE_W);
  localparam int DW = yay0_pkg::DIST_W;
  localparam int CW = yay0_pkg::CNT_W;

  logic [7:0] hist [WINDOW_DEPTH];

  logic [31:0] total_r, pos_r, pos_nxt, cbits_r, cbits_nxt;
  logic [5:0]  bleft_r, bleft_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic        done_r, done_nxt, err_r, err_nxt;
  logic [1:0]  act_r;
  logic [31:0] word_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] src_r;
  logic [7:0]  rdata_r;
  logic [7:0]  buf_r [8];
  logic [3:0]  nbuf_r;
  logic        cdone_r;
  logic        ov_r;
  logic [7:0]  ob_r [8];
  logic [3:0]  ocnt_r;
  logic        olast_r;
  logic [1:0]  ost_r;

  // item classification
  logic          is_start, pre_err, kind_ok, link_long, want_copy, copy_err;
  logic [CW-1:0] ccount;
  logic [DW-1:0] dist_eff;
  logic [32:0]   end_pos;

  always_comb begin
    is_start  = (act_r == yay0_pkg::ACT_START);
    pre_err   = done_r || err_r || (pos_r >= total_r);
    kind_ok   = 1'b0;
    unique case (kind_r)
      yay0_pkg::KIND_CMD:  kind_ok = (act_r == yay0_pkg::ACT_CMD);
      yay0_pkg::KIND_LIT:  kind_ok = (act_r == yay0_pkg::ACT_BYTE);
      yay0_pkg::KIND_LINK: kind_ok = (act_r == yay0_pkg::ACT_LINK);
      yay0_pkg::KIND_CNT:  kind_ok = (act_r == yay0_pkg::ACT_BYTE);
      default:             kind_ok = 1'b0;
    endcase
    link_long = (word_r[15:12] == 4'd0);
    dist_eff  = (kind_r == yay0_pkg::KIND_LINK) ? word_r[DW-1:0] : dist_r;
    ccount    = (kind_r == yay0_pkg::KIND_LINK) ? CW'(word_r[15:12]) + CW'(2)
                                                : CW'(word_r[7:0]) + CW'(yay0_pkg::LONG_CNT_BIAS);
    want_copy = (kind_r == yay0_pkg::KIND_CNT) ||
                ((kind_r == yay0_pkg::KIND_LINK) && !link_long);
    end_pos   = {1'b0, pos_r} + 33'(ccount);
    copy_err  = ({20'd0, dist_eff} + 32'd1 > pos_r) || (end_pos > {1'b0, total_r});
  end

  assign st.is_copy  = !is_start && !pre_err && kind_ok && want_copy && !copy_err;
  assign st.flush    = (nbuf_r == LANE_W4) || (cnt_r == '0);
  assign st.copy_end = (cnt_r == '0);
  assign st.out_free = !ov_r || !out_stall;

  // consume one command bit
  logic [31:0] adv_bits;
  logic [5:0]  adv_left;
  logic [1:0]  adv_kind;
  always_comb begin
    adv_bits = {cbits_r[30:0], 1'b0};
    adv_left = (bleft_r != 6'd0) ? bleft_r - 6'd1 : bleft_r;
    if (adv_left == 6'd0) adv_kind = yay0_pkg::KIND_CMD;
    else adv_kind = adv_bits[31] ? yay0_pkg::KIND_LIT : yay0_pkg::KIND_LINK;
  end

  logic       single_err, lit_take;
  logic [31:0] pos_inc;
  assign single_err = !is_start && (pre_err || !kind_ok || (want_copy && copy_err));
  assign lit_take   = cmd.apply_single && !single_err && !is_start &&
                      (kind_r == yay0_pkg::KIND_LIT);
  assign pos_inc    = pos_r + 32'd1;

  // stream state
  always_comb begin
    pos_nxt   = pos_r;
    cbits_nxt = cbits_r;
    bleft_nxt = bleft_r;
    kind_nxt  = kind_r;
    dist_nxt  = dist_r;
    done_nxt  = done_r;
    err_nxt   = err_r;
    if (cmd.apply_single) begin
      if (is_start) begin
        pos_nxt   = '0;
        cbits_nxt = '0;
        bleft_nxt = '0;
        kind_nxt  = yay0_pkg::KIND_CMD;
        dist_nxt  = '0;
        done_nxt  = (total_r == 32'd0);
        err_nxt   = 1'b0;
      end else if (single_err) begin
        err_nxt = 1'b1;
      end else begin
        case (kind_r)
          yay0_pkg::KIND_CMD: begin
            cbits_nxt = word_r;
            bleft_nxt = 6'd32;
            kind_nxt  = word_r[31] ? yay0_pkg::KIND_LIT : yay0_pkg::KIND_LINK;
          end
          yay0_pkg::KIND_LIT: begin
            pos_nxt = pos_inc;
            if (pos_inc == total_r) begin
              done_nxt = 1'b1;
            end else begin
              cbits_nxt = adv_bits;
              bleft_nxt = adv_left;
              kind_nxt  = adv_kind;
            end
          end
          default: begin
            dist_nxt = word_r[DW-1:0];
            kind_nxt = yay0_pkg::KIND_CNT;
          end
        endcase
      end
    end
    if (cmd.copy_start && kind_r == yay0_pkg::KIND_LINK) dist_nxt = word_r[DW-1:0];
    if (cmd.wr) pos_nxt = pos_inc;
    if (cmd.emit_copy && cnt_r == '0) begin
      if (cdone_r) begin
        done_nxt = 1'b1;
      end else begin
        cbits_nxt = adv_bits;
        bleft_nxt = adv_left;
        kind_nxt  = adv_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      pos_r   <= '0;
      cbits_r <= '0;
      bleft_r <= '0;
      kind_r  <= yay0_pkg::KIND_CMD;
      dist_r  <= '0;
      done_r  <= 1'b0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
      nbuf_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) total_r <= cfg_total_size;
      pos_r   <= pos_nxt;
      cbits_r <= cbits_nxt;
      bleft_r <= bleft_nxt;
      kind_r  <= kind_nxt;
      dist_r  <= dist_nxt;
      done_r  <= done_nxt;
      err_r   <= err_nxt;
      if (cmd.apply_single || cmd.emit_copy) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (cmd.copy_start) begin
        nbuf_r <= '0;
        cnt_r  <= ccount;
      end else if (cmd.wr) begin
        nbuf_r <= nbuf_r + 4'd1;
        cnt_r  <= cnt_r - CW'(1);
      end else if (cmd.emit_copy) begin
        nbuf_r <= '0;
      end
    end
  end

  // copy engine, history memory and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= in_action;
      word_r <= in_word;
    end
    if (cmd.copy_start) begin
      src_r   <= AW'(pos_r[AW-1:0] - AW'(dist_eff) - AW'(1));
      cdone_r <= (end_pos == {1'b0, total_r});
    end
    if (cmd.rd) begin
      rdata_r <= hist[src_r];
      src_r   <= src_r + AW'(1);
    end
    if (cmd.wr) begin
      hist[pos_r[AW-1:0]] <= rdata_r;
      buf_r[nbuf_r[2:0]]  <= rdata_r;
    end else if (lit_take) begin
      hist[pos_r[AW-1:0]] <= word_r[7:0];
    end
    if (cmd.apply_single) begin
      for (int j = 0; j < 8; j++) ob_r[j] <= 8'd0;
      ocnt_r  <= 4'd0;
      olast_r <= 1'b1;
      if (is_start) begin
        ost_r <= (total_r == 32'd0) ? yay0_pkg::ST_COMPLETE : yay0_pkg::ST_OK;
      end else if (single_err) begin
        ost_r <= yay0_pkg::ST_ERROR;
      end else if (lit_take) begin
        ob_r[0] <= word_r[7:0];
        ocnt_r  <= 4'd1;
        ost_r   <= (pos_inc == total_r) ? yay0_pkg::ST_COMPLETE : yay0_pkg::ST_OK;
      end else begin
        ost_r <= yay0_pkg::ST_OK;
      end
    end else if (cmd.emit_copy) begin
      for (int j = 0; j < 8; j++) ob_r[j] <= (4'(j) < nbuf_r) ? buf_r[j] : 8'd0;
      ocnt_r  <= nbuf_r;
      olast_r <= (cnt_r == '0);
      ost_r   <= ((cnt_r == '0) && cdone_r) ? yay0_pkg::ST_COMPLETE : yay0_pkg::ST_OK;
    end
  end

  assign out_valid      = ov_r;
  assign out_bytes      = ob_r;
  assign out_byte_count = ocnt_r;
  assign out_last       = olast_r;
  assign out_status     = ost_r;

endmodule

>>> hw/rtl/yay0_lz_decompressor_unit.sv
// ----------------------------------------------------------------------------
// yay0_lz_decompressor_unit
// Streaming Yay0 LZ decoder with a 4096-byte history window.
// ----------------------------------------------------------------------------
// One item is taken at a time. Start, command, literal and long-link items
// wait in evaluation for the result register. In a copy, each byte is read
// from and then written back to the single ported history memory, and
// results carry up to LANES (max 8) bytes each. total_size must be written
// through the cfg port while the block is idle; the block does not check.
module yay0_lz_decompressor_unit #(
  parameter int WINDOW_DEPTH = yay0_pkg::WINDOW_DEPTH_DEF,
  parameter int LANES        = yay0_pkg::LANES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [7:0]  out_byte4,
  output logic [7:0]  out_byte5,
  output logic [7:0]  out_byte6,
  output logic [7:0]  out_byte7,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_total_size
);

  yay0_pkg::cmd_t  cmd;
  yay0_pkg::stat_t st;
  logic [7:0] bytes [8];

  assign cfg_ready = 1'b1;

  yay0_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  yay0_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LANES        (LANES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_action      (in_action),
    .in_word        (in_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_total_size (cfg_total_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bytes      (bytes),
    .out_byte_count (out_byte_count),
    .out_last       (out_last),
    .out_status     (out_status)
  );

  assign out_byte0 = bytes[0];
  assign out_byte1 = bytes[1];
  assign out_byte2 = bytes[2];
  assign out_byte3 = bytes[3];
  assign out_byte4 = bytes[4];
  assign out_byte5 = bytes[5];
  assign out_byte6 = bytes[6];
  assign out_byte7 = bytes[7];

endmodule
